### rtl/core/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console character writer:
// payload structs, operation codes, control codes and controller states.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // default geometry
  localparam int DefColumns  = 80;
  localparam int DefRows     = 50;
  localparam int DefTabWidth = 8;

  // attribute after reset and the cell that reset fills the screen with
  localparam logic [7:0]  ATTR_RESET  = 8'h0F;
  localparam logic [7:0]  CHAR_BS     = 8'h08;
  localparam logic [7:0]  CHAR_TAB    = 8'h09;
  localparam logic [7:0]  CHAR_LF     = 8'h0A;
  localparam logic [7:0]  CHAR_CR     = 8'h0D;
  localparam logic [7:0]  CHAR_SPACE  = 8'h20;
  localparam logic [15:0] RESET_BLANK = {ATTR_RESET, CHAR_SPACE};

  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCROLL = 5'b00100,
    S_CLEAR  = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [5:0] read_row;
    logic [6:0] read_col;
  } in_t;

  typedef struct packed {
    logic [5:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [11:0] cursor_offset;
    logic [15:0] cell_value;
  } out_t;

  typedef struct packed {
    logic idle;   // waiting for a transaction
    logic sweep;  // blanking cells (reset pass, clear or scroll)
    logic done;   // result ready to move into the output register
  } ctrl_status_t;

endpackage

### rtl/core/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console engine: character put with control codes, scroll, clear and
// cell read over a ROWS x COLUMNS cell store.
// ----------------------------------------------------------------------------
// After reset the block fills all ROWS*COLUMNS cells (4000 by default) with
// blanks of the reset attribute and takes no transaction in that time;
// attribute writes are taken throughout. Put, read and the unused operation
// code update the cursor and touch the cell store in the idle state, then
// load the result register in the done state once the output register is free.
// A line feed or a wrap on the last row first blanks the recycled row, and a
// clear first blanks the whole screen, through the store's single write port
// one cell a cycle. The result register lets a new transaction be accepted
// while the previous result is still waiting to be taken.
module text_console_char_writer import tccw_pkg::*; #(
  parameter int COLUMNS   = DefColumns,
  parameter int ROWS      = DefRows,
  parameter int TAB_WIDTH = DefTabWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int AddrW = $clog2(ROWS) + $clog2(COLUMNS);
  localparam int ColW  = $clog2(COLUMNS);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [15:0]      mem_rdata;
  ctrl_status_t     status;

  tccw_ctrl #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .status_o    (status)
  );

  tccw_screen_mem #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_screen_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // no transaction is taken while cells are being blanked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (status.idle && !status.sweep))
    else $error("input ready during blanking sweep");

  // one transaction at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction accepted while one is in flight");

  // a result only shows up after the controller finished its work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(status.done))
    else $error("result raised without a finished transaction");

  // reads and writes of the store never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("cell store read and write in the same cycle");

  // writes stay inside the visible columns
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr[ColW-1:0]) < 32'(COLUMNS)))
    else $error("cell write beyond last column");

endmodule

### rtl/core/tccw_screen_mem.sv
// ----------------------------------------------------------------------------
// tccw_screen_mem
// Screen cell store: one write port, one read port with registered data.
// Addressed as {physical row, column}.
// ----------------------------------------------------------------------------
module tccw_screen_mem import tccw_pkg::*; #(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS    = DefRows
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]     waddr_i,
  input  logic [15:0]                                 wdata_i,
  input  logic                                        re_i,
  input  logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0]     raddr_i,
  output logic [15:0]                                 rdata_o
);

  localparam int ColW  = $clog2(COLUMNS);
  localparam int Depth = ROWS << ColW;

  logic [15:0] mem_q [Depth];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tccw_ctrl.sv
// ----------------------------------------------------------------------------
// tccw_ctrl
// Cursor, scroll offset and attribute registers, the sequencer that drives
// the cell store (writes, blanking sweeps, reads) and the output register.
// ----------------------------------------------------------------------------
module tccw_ctrl import tccw_pkg::*; #(
  parameter int COLUMNS   = DefColumns,
  parameter int ROWS      = DefRows,
  parameter int TAB_WIDTH = DefTabWidth
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  in_t                                     in_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output out_t                                    out_data_o,
  input  logic                                    cfg_we_i,
  input  logic [7:0]                              cfg_wdata_i,
  output logic                                    mem_we_o,
  output logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0] mem_waddr_o,
  output logic [15:0]                             mem_wdata_o,
  output logic                                    mem_re_o,
  output logic [$clog2(ROWS)+$clog2(COLUMNS)-1:0] mem_raddr_o,
  input  logic [15:0]                             mem_rdata_i,
  output ctrl_status_t                            status_o
);

  localparam int RowW = $clog2(ROWS);
  localparam int ColW = $clog2(COLUMNS);
  localparam int TabW = $clog2(TAB_WIDTH);
  localparam int NxtW = $clog2(COLUMNS + TAB_WIDTH);
  localparam int OffW = $clog2(ROWS * COLUMNS);

  localparam logic [RowW:0]   RowsX    = (RowW+1)'(ROWS);
  localparam logic [RowW-1:0] LastRow  = RowW'(ROWS - 1);
  localparam logic [ColW-1:0] LastCol  = ColW'(COLUMNS - 1);
  localparam logic [TabW-1:0] LastTab  = TabW'(TAB_WIDTH - 1);
  localparam logic [NxtW-1:0] ColsN    = NxtW'(COLUMNS);
  localparam logic [NxtW-1:0] TabN     = NxtW'(TAB_WIDTH);
  localparam logic [OffW-1:0] ColsO    = OffW'(COLUMNS);

  // logical row to physical row: both operands below ROWS
  function automatic logic [RowW-1:0] phys_row(input logic [RowW-1:0] top,
                                                input logic [RowW-1:0] row);
    logic [RowW:0] sum;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= RowsX) begin
      sum = sum - RowsX;
    end
    return sum[RowW-1:0];
  endfunction

  state_e          state_q, state_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [TabW-1:0] phase_q, phase_d;  // col_q modulo TAB_WIDTH
  logic [RowW-1:0] top_q, top_d;
  logic [7:0]      attr_q;
  logic [RowW-1:0] sw_row_q, sw_row_d;
  logic [ColW-1:0] sw_col_q, sw_col_d;
  logic            cell_sel_q, cell_sel_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  logic            accept;
  logic            out_free;
  logic [NxtW-1:0] ncol;
  logic [TabW-1:0] nphase;
  logic            lf;
  logic            print;
  logic            new_line;
  logic [15:0]     blank;
  logic [OffW-1:0] offset;
  logic            rd_in_range;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign blank      = (state_q == S_INIT) ? RESET_BLANK : {attr_q, CHAR_SPACE};
  assign offset     = OffW'(row_q) * ColsO + OffW'(col_q);

  assign rd_in_range = (32'(in_data_i.read_row) < 32'(ROWS)) &&
                       (32'(in_data_i.read_col) < 32'(COLUMNS));

  // cursor motion for a put transaction
  always_comb begin
    ncol   = NxtW'(col_q);
    nphase = phase_q;
    lf     = 1'b0;
    print  = 1'b0;
    unique case (in_data_i.char_code)
      CHAR_BS: begin
        if (col_q != '0) begin
          ncol   = NxtW'(col_q) - NxtW'(1);
          nphase = (phase_q == '0) ? LastTab : phase_q - TabW'(1);
        end
      end
      CHAR_TAB: begin
        ncol   = NxtW'(col_q) + TabN - NxtW'(phase_q);
        nphase = '0;
      end
      CHAR_CR: begin
        ncol   = '0;
        nphase = '0;
      end
      CHAR_LF: begin
        lf = 1'b1;
      end
      default: begin
        if (in_data_i.char_code >= CHAR_SPACE) begin
          print  = 1'b1;
          ncol   = NxtW'(col_q) + NxtW'(1);
          nphase = (phase_q == LastTab) ? '0 : phase_q + TabW'(1);
        end
      end
    endcase
    new_line = lf || (ncol >= ColsN);
  end

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    phase_d     = phase_q;
    top_d       = top_q;
    sw_row_d    = sw_row_q;
    sw_col_d    = sw_col_q;
    cell_sel_d  = cell_sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = {sw_row_q, sw_col_q};
    mem_wdata_o = blank;
    mem_re_o    = 1'b0;
    mem_raddr_o = {phys_row(top_q, RowW'(in_data_i.read_row)),
                   ColW'(in_data_i.read_col)};

    unique case (state_q)
      S_INIT, S_CLEAR: begin
        mem_we_o = 1'b1;
        if (sw_col_q == LastCol) begin
          sw_col_d = '0;
          if (sw_row_q == LastRow) begin
            sw_row_d = '0;
            state_d  = (state_q == S_INIT) ? S_IDLE : S_DONE;
          end else begin
            sw_row_d = sw_row_q + RowW'(1);
          end
        end else begin
          sw_col_d = sw_col_q + ColW'(1);
        end
      end
      S_SCROLL: begin
        mem_we_o = 1'b1;
        if (sw_col_q == LastCol) begin
          sw_col_d = '0;
          state_d  = S_DONE;
        end else begin
          sw_col_d = sw_col_q + ColW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d    = S_DONE;
          cell_sel_d = 1'b0;
          unique case (in_data_i.func)
            FUNC_PUT: begin
              mem_we_o    = print;
              mem_waddr_o = {phys_row(top_q, row_q), col_q};
              mem_wdata_o = {attr_q, in_data_i.char_code};
              if (new_line) begin
                col_d   = '0;
                phase_d = '0;
                if (row_q == LastRow) begin
                  // recycle the old top row as the new bottom row
                  top_d    = (top_q == LastRow) ? '0 : top_q + RowW'(1);
                  sw_row_d = top_q;
                  sw_col_d = '0;
                  state_d  = S_SCROLL;
                end else begin
                  row_d = row_q + RowW'(1);
                end
              end else begin
                col_d   = ncol[ColW-1:0];
                phase_d = nphase;
              end
            end
            FUNC_CLEAR: begin
              row_d    = '0;
              col_d    = '0;
              phase_d  = '0;
              top_d    = '0;
              sw_row_d = '0;
              sw_col_d = '0;
              state_d  = S_CLEAR;
            end
            FUNC_READ: begin
              mem_re_o   = rd_in_range;
              cell_sel_d = rd_in_range;
            end
            default: begin
            end
          endcase
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_d.cursor_row        = 6'(row_q);
          out_d.cursor_col        = 7'(col_q);
          out_d.cursor_offset     = 12'(offset);
          out_d.cell_value        = cell_sel_q ? mem_rdata_i : 16'h0000;
          state_d                 = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      row_q       <= '0;
      col_q       <= '0;
      phase_q     <= '0;
      top_q       <= '0;
      attr_q      <= ATTR_RESET;
      sw_row_q    <= '0;
      sw_col_q    <= '0;
      cell_sel_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      phase_q     <= phase_d;
      top_q       <= top_d;
      sw_row_q    <= sw_row_d;
      sw_col_q    <= sw_col_d;
      cell_sel_q  <= cell_sel_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;
  assign status_o.idle  = (state_q == S_IDLE);
  assign status_o.sweep = (state_q == S_INIT) || (state_q == S_CLEAR) ||
                          (state_q == S_SCROLL);
  assign status_o.done  = (state_q == S_DONE);

endmodule
